/* rtl/utf8sv_pkg.sv */
package utf8sv_pkg;

	localparam logic [7:0] ASCII_MAX  = 8'h7f;
	localparam logic [7:0] LEAD2_MIN  = 8'hc2;
	localparam logic [7:0] LEAD2_MAX  = 8'hdf;
	localparam logic [7:0] LEAD3_MIN  = 8'he0;
	localparam logic [7:0] LEAD3_MAX  = 8'hef;
	localparam logic [7:0] LEAD3_SURR = 8'hed;
	localparam logic [7:0] LEAD4_MIN  = 8'hf0;
	localparam logic [7:0] LEAD4_MAX  = 8'hf4;
	localparam logic [7:0] BOUND3     = 8'ha0;
	localparam logic [7:0] BOUND4     = 8'h90;
	localparam logic [7:0] CONT_MASK  = 8'hc0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	typedef enum logic [1:0] {
		RULE_NONE  = 2'd0,
		RULE_LOWER = 2'd1,
		RULE_UPPER = 2'd2
	} rule_t;

	typedef struct packed {
		logic [1:0] bytes_owed;
		rule_t      second_byte_rule;
		logic       failed;
	} scan_state_t;

	typedef struct packed {
		scan_state_t next;
		logic        emit;
		logic        verdict;
	} step_result_t;

	localparam scan_state_t STATE_CLEAR = '{bytes_owed: 2'd0,
		second_byte_rule: RULE_NONE, failed: 1'b0};

endpackage

/* rtl/utf8sv_step.sv */
module utf8sv_step (
	input  utf8sv_pkg::scan_state_t  cur,
	input  logic [7:0]               data_byte,
	input  logic                     last,
	input  logic                     empty_req,
	output utf8sv_pkg::step_result_t res
);
	import utf8sv_pkg::*;

	scan_state_t taken;
	logic [7:0]  bound;
	logic        cont_ok;

	always_comb begin
		taken   = cur;
		bound   = (cur.bytes_owed == 2'd2) ? BOUND3 : BOUND4;
		cont_ok = (data_byte & CONT_MASK) == CONT_TAG;
		if (cur.second_byte_rule == RULE_LOWER && data_byte < bound) begin
			cont_ok = 1'b0;
		end
		if (cur.second_byte_rule == RULE_UPPER && data_byte >= bound) begin
			cont_ok = 1'b0;
		end
		if (!cur.failed) begin
			if (cur.bytes_owed != 2'd0) begin
				if (!cont_ok) begin
					taken.failed = 1'b1;
				end else begin
					taken.bytes_owed       = cur.bytes_owed - 2'd1;
					taken.second_byte_rule = RULE_NONE;
				end
			end else if (data_byte == 8'd0) begin
				taken.failed = 1'b1;
			end else if (data_byte <= ASCII_MAX) begin
				taken = cur;
			end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
				taken.bytes_owed       = 2'd1;
				taken.second_byte_rule = RULE_NONE;
			end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
				taken.bytes_owed       = 2'd2;
				taken.second_byte_rule = (data_byte == LEAD3_MIN) ? RULE_LOWER
					: (data_byte == LEAD3_SURR) ? RULE_UPPER : RULE_NONE;
			end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
				taken.bytes_owed       = 2'd3;
				taken.second_byte_rule = (data_byte == LEAD4_MIN) ? RULE_LOWER
					: (data_byte == LEAD4_MAX) ? RULE_UPPER : RULE_NONE;
			end else begin
				taken.failed = 1'b1;
			end
		end

		res.emit    = empty_req | last;
		res.verdict = 1'b0;
		res.next    = taken;
		if (empty_req) begin
			res.verdict = !cur.failed && cur.bytes_owed == 2'd0;
			res.next    = STATE_CLEAR;
		end else if (last) begin
			res.verdict = !taken.failed && taken.bytes_owed == 2'd0;
			res.next    = STATE_CLEAR;
		end
	end

endmodule

/* rtl/utf8_stream_validator.sv */
// Channel  Handshake            Payload
// in       in_valid/in_ready    data_byte, last, empty_req
// out      out_valid/out_ready  string_valid
//
// One item per cycle unless a stalled result holds the input; verdicts are registered.
// Path: input register, one step of the scan state, result register.
// arst_n clears the scan state and both valid flags.
// A stalled result holds the input register only when that item ends a string.
module utf8_stream_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  logic       empty_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       string_valid
);
	import utf8sv_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         empty_s1;
	scan_state_t  state_q;
	step_result_t step;
	logic         adv;
	logic         out_valid_q;
	logic         string_valid_q;

	utf8sv_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.last      (last_s1),
		.empty_req (empty_s1),
		.res       (step)
	);

	assign adv      = valid_s1 && (!step.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			last_s1  <= last;
			empty_s1 <= empty_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (adv) begin
			state_q <= step.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && step.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step.emit) begin
			string_valid_q <= step.verdict;
		end
	end

	assign out_valid    = out_valid_q;
	assign string_valid = string_valid_q;

`ifndef SYNTH
	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && step.emit) |=> (state_q.bytes_owed == 2'd0 && !state_q.failed))
		else $error("scan state not cleared after verdict");
	a_rule_needs_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.second_byte_rule != RULE_NONE) |-> (state_q.bytes_owed >= 2'd2))
		else $error("second byte rule without multi-byte sequence");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1 && step.emit) |-> !in_ready)
		else $error("verdict would overwrite pending result");
`endif

endmodule
